@@ rtl/smes_pkg.sv @@
// Shared types and constants for the sparse matrix element store.
`default_nettype none
package smes_pkg;
    localparam int Entries    = 32;
    localparam int IndexBits  = 10;
    localparam int ValueBits  = 32;
    localparam int AddrBits   = $clog2(Entries);
    localparam int CountBits  = $clog2(Entries + 1);

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_DUMP  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         out_row;
        logic [9:0]         out_col;
        logic signed [31:0] out_value;
        logic               present;
        logic               status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [IndexBits-1:0] row;
        logic [IndexBits-1:0] col;
        logic [ValueBits-1:0] value;
    } t_cell;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

@@ rtl/smes_ram.sv @@
// Cell memory: one write port, one registered read port.
`default_nettype none
module smes_ram (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [smes_pkg::AddrBits-1:0] i_waddr,
    input  wire smes_pkg::t_cell          i_wdata,
    input  wire logic [smes_pkg::AddrBits-1:0] i_raddr,
    output smes_pkg::t_cell               o_rdata
);
    import smes_pkg::*;

    t_cell r_mem [Entries];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/sparse_matrix_element_store.sv @@
// Top level: sorted sparse matrix cell store with set, get, dump and clear.
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_ready   t_in_item
//   out      output     o_out_valid/i_out_ready t_out_item
// Set and get scan the sorted cells through the memory read port, one cell a
// cycle, and stop at the first cell whose key is not below the item's key.
// Insert and delete then shift the later cells up or down by one place.
// Dump streams cells in order via DUMP_RD and DUMP_OUT; clear zeroes the count.
// Reset empties the store at once (count zero); no clearing pass.
// A stalled result holds the block; a new item is taken only once idle.
`default_nettype none
module sparse_matrix_element_store (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire smes_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output smes_pkg::t_out_item      o_out_data
);
    import smes_pkg::*;

    localparam logic [AddrBits-1:0] AddrLast = AddrBits'(Entries - 1);

    t_state r_state, n_state;
    logic [CountBits-1:0] r_count, n_count;
    logic [CountBits-1:0] r_pos, n_pos;
    logic [CountBits-1:0] r_mv, n_mv;
    logic                 r_hit, n_hit;
    t_in_item             r_item, n_item;
    t_out_item            r_out, n_out;
    logic                 r_ov, n_ov;
    logic                 r_del, n_del;
    logic                 r_hold, n_hold;
    t_cell                r_carry, n_carry;

    logic                 we;
    logic [AddrBits-1:0]  waddr, raddr;
    t_cell                wdata, rdata;

    logic [2*IndexBits-1:0] key_in, key_rd;
    logic [ValueBits-1:0]   val_in;

    smes_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign key_in = {r_item.row[IndexBits-1:0], r_item.col[IndexBits-1:0]};
    assign key_rd = {rdata.row, rdata.col};
    assign val_in = ValueBits'(r_item.value);
    assign o_in_ready  = (r_state == ST_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
        r_pos   <= n_pos;
        r_mv    <= n_mv;
        r_hit   <= n_hit;
        r_item  <= n_item;
        r_out   <= n_out;
        r_del   <= n_del;
        r_hold  <= n_hold;
        r_carry <= n_carry;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_mv    = r_mv;
        n_hit   = r_hit;
        n_item  = r_item;
        n_out   = r_out;
        n_ov    = r_ov && !i_out_ready;
        n_del   = r_del;
        n_hold  = r_hold;
        n_carry = r_carry;
        we      = 1'b0;
        waddr   = r_pos[AddrBits-1:0];
        wdata   = r_carry;
        raddr   = r_pos[AddrBits-1:0];
        unique case (r_state)
            ST_IDLE: begin
                raddr = '0;
                if (i_in_valid && o_in_ready) begin
                    n_item = i_in_data;
                    n_pos  = '0;
                    n_hit  = 1'b0;
                    unique case (t_op'(i_in_data.op))
                        OP_SET, OP_GET: n_state = ST_SEARCH;
                        OP_DUMP:        n_state = ST_DUMP_RD;
                        default: begin
                            n_count = '0;
                            n_out   = '0;
                            n_out.last = 1'b1;
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // rdata holds cell r_pos when r_pos < count; stop at first key >= ours
                if (r_pos < r_count && key_rd < key_in) begin
                    n_pos = r_pos + 1'b1;
                    raddr = n_pos[AddrBits-1:0];
                end else begin
                    n_hit = (r_pos < r_count) && (key_rd == key_in);
                    n_out = '0;
                    n_out.out_row = r_item.row;
                    n_out.out_col = r_item.col;
                    n_out.last    = 1'b1;
                    n_state       = ST_EMIT;
                    if (t_op'(r_item.op) == OP_GET) begin
                        if (n_hit) begin
                            n_out.out_value = 32'(signed'(rdata.value));
                            n_out.present   = 1'b1;
                        end
                    end else if (val_in != '0) begin
                        if (n_hit) begin
                            we = 1'b1;
                            wdata = '{row: rdata.row, col: rdata.col, value: val_in};
                            n_out.out_value = 32'(signed'(val_in));
                            n_out.present   = 1'b1;
                        end else if (r_count >= CountBits'(Entries)) begin
                            n_out.status = 1'b1;
                        end else begin
                            // write new cell at pos, carry old cells upward
                            we = 1'b1;
                            wdata = '{row: r_item.row[IndexBits-1:0],
                                      col: r_item.col[IndexBits-1:0], value: val_in};
                            n_carry = rdata;
                            n_hold  = r_pos < r_count;
                            n_del   = 1'b0;
                            n_mv    = r_pos + 1'b1;
                            n_count = r_count + 1'b1;
                            n_out.out_value = 32'(signed'(val_in));
                            n_out.present   = 1'b1;
                            raddr   = n_mv[AddrBits-1:0];
                            n_state = ST_SHIFT;
                        end
                    end else if (n_hit) begin
                        // delete: pull cells down from pos+1
                        n_del   = 1'b1;
                        n_mv    = r_pos + 1'b1;
                        n_count = r_count - 1'b1;
                        raddr   = n_mv[AddrBits-1:0];
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                raddr = r_mv[AddrBits-1:0] + 1'b1;
                if (r_del) begin
                    if (r_mv < CountBits'(r_count + 1'b1)) begin
                        we    = 1'b1;
                        waddr = r_mv[AddrBits-1:0] - 1'b1;
                        wdata = rdata;
                        n_mv  = r_mv + 1'b1;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    if (r_hold && r_mv < r_count) begin
                        we      = 1'b1;
                        waddr   = r_mv[AddrBits-1:0];
                        wdata   = r_carry;
                        n_carry = rdata;
                        n_hold  = r_mv + 1'b1 < r_count;
                        n_mv    = r_mv + 1'b1;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
                if (r_mv[AddrBits-1:0] == AddrLast) begin
                    raddr = AddrLast;
                end
            end
            ST_DUMP_RD: begin
                if (r_count == '0) begin
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_DUMP_OUT;
                end
            end
            ST_DUMP_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_out.out_row   = 10'(rdata.row);
                    n_out.out_col   = 10'(rdata.col);
                    n_out.out_value = 32'(signed'(rdata.value));
                    n_out.present   = 1'b1;
                    n_out.status    = 1'b0;
                    n_out.last      = (r_pos + 1'b1) == r_count;
                    n_ov  = 1'b1;
                    n_pos = r_pos + 1'b1;
                    raddr = n_pos[AddrBits-1:0];
                    n_state = n_out.last ? ST_IDLE : ST_DUMP_RD;
                end
            end
            ST_EMIT: begin
                n_ov    = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Count never exceeds capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(Entries)) else $error("count over capacity");

    // A pending result is held until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_out_ready |=> r_ov && $stable(r_out)) else $error("result lost");

    // Input is refused while a result is pending.
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !o_in_ready) else $error("accept during pending result");
endmodule
`default_nettype wire

@@ verif/tb_sparse_matrix_element_store.sv @@
// Self-checking testbench for the sparse matrix element store: set, get, dump and clear.
`default_nettype none
module tb_sparse_matrix_element_store;
    timeunit 1ns;
    timeprecision 1ps;
    import smes_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    sparse_matrix_element_store dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the sorted cell array.
    logic [9:0]  mat_row [Entries];
    logic [9:0]  mat_col [Entries];
    logic [31:0] mat_val [Entries];
    int          mat_count;

    t_out_item   expected_q[$];
    int          error_count;
    int          result_count;
    int          sent_count;
    int          dump_count;
    int          full_count;
    bit          quiet;

    function automatic t_out_item make_result(logic [9:0] r, logic [9:0] c, logic [31:0] v,
                                              logic p, logic s, logic l);
        t_out_item o;
        o.out_row = r;
        o.out_col = c;
        o.out_value = v;
        o.present = p;
        o.status = s;
        o.last = l;
        return o;
    endfunction

    // Compute the results of one item and update the shadow store.
    task automatic predict_matrix(t_in_item it);
        int         pos;
        bit         hit;
        logic [19:0] key;
        key = {it.row, it.col};
        pos = 0;
        while (pos < mat_count && {mat_row[pos], mat_col[pos]} < key) pos++;
        hit = (pos < mat_count) && ({mat_row[pos], mat_col[pos]} == key);
        case (t_op'(it.op))
            OP_SET: begin
                if (it.value != 0) begin
                    if (hit) begin
                        mat_val[pos] = it.value;
                        expected_q.push_back(make_result(it.row, it.col, it.value, 1, 0, 1));
                    end else if (mat_count >= Entries) begin
                        full_count++;
                        expected_q.push_back(make_result(it.row, it.col, 0, 0, 1, 1));
                    end else begin
                        for (int i = mat_count; i > pos; i--) begin
                            mat_row[i] = mat_row[i-1];
                            mat_col[i] = mat_col[i-1];
                            mat_val[i] = mat_val[i-1];
                        end
                        mat_row[pos] = it.row;
                        mat_col[pos] = it.col;
                        mat_val[pos] = it.value;
                        mat_count++;
                        expected_q.push_back(make_result(it.row, it.col, it.value, 1, 0, 1));
                    end
                end else begin
                    if (hit) begin
                        for (int i = pos; i + 1 < mat_count; i++) begin
                            mat_row[i] = mat_row[i+1];
                            mat_col[i] = mat_col[i+1];
                            mat_val[i] = mat_val[i+1];
                        end
                        mat_count--;
                    end
                    expected_q.push_back(make_result(it.row, it.col, 0, 0, 0, 1));
                end
            end
            OP_GET: begin
                if (hit)
                    expected_q.push_back(make_result(it.row, it.col, mat_val[pos], 1, 0, 1));
                else
                    expected_q.push_back(make_result(it.row, it.col, 0, 0, 0, 1));
            end
            OP_DUMP: begin
                dump_count++;
                if (mat_count == 0)
                    expected_q.push_back(make_result(0, 0, 0, 0, 0, 1));
                for (int i = 0; i < mat_count; i++)
                    expected_q.push_back(make_result(mat_row[i], mat_col[i], mat_val[i],
                                                     1, 0, i + 1 == mat_count));
            end
            default: begin
                mat_count = 0;
                expected_q.push_back(make_result(0, 0, 0, 0, 0, 1));
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch at result %0d: %s got %0h want %0h", result_count, what, got, want);
    endtask

    // Drive one item, with an optional random gap in front of it.
    task automatic send_item(logic [1:0] op, logic [9:0] r, logic [9:0] c, logic [31:0] v);
        t_in_item it;
        it.op = op;
        it.row = r;
        it.col = c;
        it.value = v;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_matrix(it);
        sent_count++;
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (Entries + 8) @(posedge i_clk);
    endtask

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_out_item w;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result at row", 32'(o_out_data.out_row), 32'(0));
            end else begin
                w = expected_q.pop_front();
                if (o_out_data.out_row !== w.out_row)
                    report_mismatch("out_row", 32'(o_out_data.out_row), 32'(w.out_row));
                if (o_out_data.out_col !== w.out_col)
                    report_mismatch("out_col", 32'(o_out_data.out_col), 32'(w.out_col));
                if (o_out_data.out_value !== w.out_value)
                    report_mismatch("out_value", 32'(o_out_data.out_value),
                                    32'(w.out_value));
                if (o_out_data.present !== w.present)
                    report_mismatch("present", 32'(o_out_data.present), 32'(w.present));
                if (o_out_data.status !== w.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(w.status));
                if (o_out_data.last !== w.last)
                    report_mismatch("last", 32'(o_out_data.last), 32'(w.last));
            end
            result_count++;
        end
    end

    // Stall the result side in random bursts.
    initial begin
        forever begin
            @(posedge i_clk);
            if (quiet || $urandom_range(0, 5) != 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(posedge i_clk);
            end
        end
    end

    task automatic test_directed;
        send_item(OP_DUMP, 0, 0, 0);
        send_item(OP_GET, 5, 5, 0);
        send_item(OP_SET, 5, 5, 0);
        send_item(OP_SET, 0, 0, 32'h7fffffff);
        send_item(OP_SET, 10'h3ff, 10'h3ff, 32'h80000000);
        send_item(OP_SET, 10'h3ff, 0, 32'hffffffff);
        send_item(OP_SET, 0, 10'h3ff, 1);
        send_item(OP_SET, 5, 7, 42);
        send_item(OP_SET, 5, 7, -42);
        send_item(OP_GET, 5, 7, 0);
        send_item(OP_GET, 10'h3ff, 10'h3ff, 0);
        send_item(OP_DUMP, 0, 0, 0);
        send_item(OP_SET, 5, 7, 0);
        send_item(OP_GET, 5, 7, 0);
        send_item(OP_DUMP, 0, 0, 0);
        send_item(OP_CLEAR, 10'h3ff, 10'h3ff, 32'hffffffff);
        send_item(OP_DUMP, 0, 0, 0);
    endtask

    task automatic test_full_store;
        // Pause until all results are in before filling the store.
        wait_drained();
        for (int i = 0; i < Entries; i++)
            send_item(OP_SET, 10'($urandom_range(0, 3)), 10'(i * 31), $urandom | 1);
        send_item(OP_SET, 10'h3ff, 10'h3fe, 32'h5);
        send_item(OP_GET, 10'h3ff, 10'h3fe, 0);
        send_item(OP_DUMP, 0, 0, 0);
        send_item(OP_SET, 0, 0, 0);
        send_item(OP_SET, 10'h3ff, 10'h3fe, 32'h5);
        send_item(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random;
        int pick;
        for (int n = 0; n < 55; n++) begin
            if (n == 45) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_item(OP_SET, 10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)),
                          ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom);
            else if (pick < 60)
                send_item(OP_SET, 10'($urandom), 10'($urandom), $urandom);
            else if (pick < 85)
                send_item(OP_GET, 10'($urandom_range(0, 7)), 10'($urandom_range(0, 7)),
                          $urandom);
            else if (pick < 97)
                send_item(OP_DUMP, 10'($urandom), 10'($urandom), $urandom);
            else
                send_item(OP_CLEAR, 10'($urandom), 10'($urandom), $urandom);
        end
    endtask

    initial begin
        error_count = 0;
        result_count = 0;
        sent_count = 0;
        dump_count = 0;
        full_count = 0;
        mat_count = 0;
        quiet = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_random();
        wait_drained();
        $display("covered %0d items, %0d results, %0d dumps, %0d full-store drops",
                 sent_count, result_count, dump_count, full_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/smes_pkg.sv
rtl/smes_ram.sv
rtl/sparse_matrix_element_store.sv
verif/tb_sparse_matrix_element_store.sv
